### rtl/cse_pkg.sv
package cse_pkg;

    // fixed field widths
    localparam int POINT_W     = 18;
    localparam int COEF_W      = 32;
    localparam int OUT_W       = 32;
    localparam int ACC_W       = 46;
    localparam int PROD_W      = 64;
    localparam int TERMS_W     = 3;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 1;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    // saturation limits of the recurrence registers and of the result
    localparam logic signed [PROD_W-1:0] ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam logic signed [PROD_W-1:0] ACC_MIN = -(64'sd1 <<< (ACC_W - 1));
    localparam logic signed [PROD_W-1:0] OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam logic signed [PROD_W-1:0] OUT_MIN = -(64'sd1 <<< (OUT_W - 1));

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_ADD  = 3'b100
    } t_state;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NUM_TERMS  = 3'd0,
        REG_COEF_ZERO  = 3'd1,
        REG_COEF_ONE   = 3'd2,
        REG_COEF_TWO   = 3'd3,
        REG_COEF_THREE = 3'd4,
        REG_COEF_FOUR  = 3'd5,
        REG_COEF_FIVE  = 3'd6,
        REG_COEF_SIX   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic mul_en;
        logic final_step;
    } t_mac_ctrl;

endpackage

### rtl/cse_ram.sv
module cse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 7,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q_a;
    logic [WIDTH-1:0] r_q_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q_a <= r_mem[i_raddr_a];
        r_q_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_q_a;
    assign o_rdata_b = r_q_b;

endmodule

### rtl/cse_mac.sv
module cse_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  cse_pkg::t_mac_ctrl                  i_ctrl,
    input  logic signed [cse_pkg::POINT_W-1:0]  i_x,
    input  logic signed [cse_pkg::ACC_W-1:0]    i_b1,
    input  logic signed [cse_pkg::ACC_W-1:0]    i_b2,
    input  logic signed [cse_pkg::COEF_W-1:0]   i_coef,
    output logic signed [cse_pkg::ACC_W-1:0]    o_res,
    output logic                                o_clip
);

    localparam int PW = cse_pkg::PROD_W;
    localparam int AW = cse_pkg::ACC_W;
    // half of one output lsb, for the 2*x*b step and for the final x*b step
    localparam logic signed [PW-1:0] RND_STEP = 64'sd1 <<< (FRAC_BITS - 2);
    localparam logic signed [PW-1:0] RND_FIN  = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] rnd_sum;
    logic signed [PW-1:0] t_val;
    logic signed [PW-1:0] sum;
    logic signed [PW-1:0] lo;
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] clipped;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_x * i_b1;
        end
    end

    always_comb begin
        rnd_sum = r_prod + (i_ctrl.final_step ? RND_FIN : RND_STEP);
        // shifting one bit less doubles the product
        t_val   = i_ctrl.final_step ? (rnd_sum >>> FRAC_BITS) : (rnd_sum >>> (FRAC_BITS - 1));
        sum     = PW'(i_coef) + t_val - PW'(i_b2);
        lo      = i_ctrl.final_step ? cse_pkg::OUT_MIN : cse_pkg::ACC_MIN;
        hi      = i_ctrl.final_step ? cse_pkg::OUT_MAX : cse_pkg::ACC_MAX;
        if (sum < lo) begin
            clipped = lo;
            o_clip  = 1'b1;
        end else if (sum > hi) begin
            clipped = hi;
            o_clip  = 1'b1;
        end else begin
            clipped = sum;
            o_clip  = 1'b0;
        end
        o_res = clipped[AW-1:0];
    end

endmodule

### rtl/chebyshev_series_eval.sv
// channel   direction  transaction             payload
// s_axis    in         s_axis_tvalid/tready    tdata[17:0] point
// m_axis    out        m_axis_tvalid/tready    tdata[31:0] series_value, tuser[0] saturated
// apb       in/out     psel & penable & pwrite num_terms, coef_zero .. coef_six at 4*i
//
// a point is evaluated term by term, with the term count clamped to 1 .. MAX_TERMS: the
// shared multiplier and the add/clamp step of cse_mac run one after the other per term
// reset is synchronous, active low; it clears the sequencer, the output valid, the
// coefficient valid bits (so every coefficient reads as zero) and sets num_terms to 1
// s_axis_tready is high only while the sequencer is idle; the last step holds while
// the output register still carries a result that m_axis has not taken
module chebyshev_series_eval #(
    parameter int MAX_TERMS = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cse_pkg::S_TDATA_W-1:0]       s_axis_tdata,   // [17:0] point
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cse_pkg::M_TDATA_W-1:0]       m_axis_tdata,   // [31:0] series_value
    output logic [cse_pkg::M_TUSER_W-1:0]       m_axis_tuser,   // [0] saturated
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cse_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cse_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cse_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int RW    = cse_pkg::REG_IDX_W;

    cse_pkg::t_state                       r_state;
    cse_pkg::t_state                       n_state;
    logic [cse_pkg::TERMS_W-1:0]           r_num_terms;
    logic [MAX_TERMS-1:0]                  r_coef_vld;
    logic signed [cse_pkg::POINT_W-1:0]    r_x;
    logic signed [cse_pkg::ACC_W-1:0]      r_b1;
    logic signed [cse_pkg::ACC_W-1:0]      r_b2;
    logic                                  r_sat;
    logic [IDX_W-1:0]                      r_idx;
    logic                                  r_a_vld;
    logic                                  r_rd_vld;
    logic [RW-1:0]                         r_rd_reg;
    logic                                  r_m_valid;
    logic [cse_pkg::OUT_W-1:0]             r_m_data;
    logic                                  r_m_sat;

    logic                                  cfg_wr;
    logic [RW-1:0]                         reg_idx;
    logic [RW-1:0]                         coef_slot;
    logic                                  slot_ok;
    logic                                  coef_we;
    logic                                  in_acc;
    logic                                  final_step;
    logic                                  out_free;
    logic                                  finish;
    logic [cse_pkg::TERMS_W-1:0]           start_idx;
    logic [cse_pkg::COEF_W-1:0]            q_a;
    logic [cse_pkg::COEF_W-1:0]            q_b;
    logic signed [cse_pkg::COEF_W-1:0]     coef_use;
    cse_pkg::t_mac_ctrl                    mac_ctrl;
    logic signed [cse_pkg::ACC_W-1:0]      mac_res;
    logic                                  mac_clip;

    // configuration decode
    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite & pready;
    assign reg_idx   = paddr[cse_pkg::APB_ADDR_W-1:2];
    assign coef_slot = reg_idx - RW'(cse_pkg::REG_COEF_ZERO);
    assign slot_ok   = (reg_idx != cse_pkg::REG_NUM_TERMS) && (coef_slot < RW'(MAX_TERMS));
    assign coef_we   = cfg_wr && slot_ok;

    assign in_acc     = s_axis_tvalid & s_axis_tready;
    assign final_step = (r_idx == '0);
    assign out_free   = !r_m_valid || m_axis_tready;
    assign finish     = (r_state == cse_pkg::ST_ADD) && final_step && out_free;

    // clamp the term count to 1 .. MAX_TERMS and count down from the top coefficient
    always_comb begin
        if (r_num_terms == '0) begin
            start_idx = '0;
        end else if (r_num_terms > cse_pkg::TERMS_W'(MAX_TERMS)) begin
            start_idx = cse_pkg::TERMS_W'(MAX_TERMS - 1);
        end else begin
            start_idx = r_num_terms - cse_pkg::TERMS_W'(1);
        end
    end

    cse_ram #(
        .WIDTH (cse_pkg::COEF_W),
        .DEPTH (MAX_TERMS)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_we      (coef_we),
        .i_waddr   (coef_slot[IDX_W-1:0]),
        .i_wdata   (pwdata),
        .i_raddr_a (r_idx),
        .o_rdata_a (q_a),
        .i_raddr_b (coef_slot[IDX_W-1:0]),
        .o_rdata_b (q_b)
    );

    // a coefficient never written reads as zero
    assign coef_use = r_a_vld ? $signed(q_a) : '0;

    assign mac_ctrl.mul_en     = (r_state == cse_pkg::ST_MUL);
    assign mac_ctrl.final_step = final_step;

    cse_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (mac_ctrl),
        .i_x     (r_x),
        .i_b1    (r_b1),
        .i_b2    (r_b2),
        .i_coef  (coef_use),
        .o_res   (mac_res),
        .o_clip  (mac_clip)
    );

    always_comb begin
        case (r_state)
            cse_pkg::ST_IDLE: n_state = in_acc ? cse_pkg::ST_MUL : cse_pkg::ST_IDLE;
            cse_pkg::ST_MUL:  n_state = cse_pkg::ST_ADD;
            cse_pkg::ST_ADD: begin
                if (!final_step) begin
                    n_state = cse_pkg::ST_MUL;
                end else if (out_free) begin
                    n_state = cse_pkg::ST_IDLE;
                end else begin
                    n_state = cse_pkg::ST_ADD;
                end
            end
            default: n_state = cse_pkg::ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == cse_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cse_pkg::ST_IDLE;
            r_num_terms <= cse_pkg::TERMS_W'(1);
            r_coef_vld  <= '0;
            r_m_valid   <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && (reg_idx == cse_pkg::REG_NUM_TERMS)) begin
                r_num_terms <= pwdata[cse_pkg::TERMS_W-1:0];
            end
            if (coef_we) begin
                r_coef_vld[coef_slot[IDX_W-1:0]] <= 1'b1;
            end
            if (in_acc) begin
                r_idx <= start_idx[IDX_W-1:0];
            end else if ((r_state == cse_pkg::ST_ADD) && !final_step) begin
                r_idx <= r_idx - IDX_W'(1);
            end
            if (finish) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // datapath registers: the point loads on acceptance, the recurrence per step, the result at the finish
    always_ff @(posedge i_clk) begin
        r_a_vld  <= r_coef_vld[r_idx];
        r_rd_reg <= reg_idx;
        r_rd_vld <= slot_ok && r_coef_vld[coef_slot[IDX_W-1:0]];
        if (in_acc) begin
            r_x   <= $signed(s_axis_tdata[cse_pkg::POINT_W-1:0]);
            r_b1  <= '0;
            r_b2  <= '0;
            r_sat <= 1'b0;
        end else if ((r_state == cse_pkg::ST_ADD) && !final_step) begin
            r_b2  <= r_b1;
            r_b1  <= mac_res;
            r_sat <= r_sat | mac_clip;
        end
        if (finish) begin
            r_m_data <= mac_res[cse_pkg::OUT_W-1:0];
            r_m_sat  <= r_sat | mac_clip;
        end
    end

    always_comb begin
        if (r_rd_reg == cse_pkg::REG_NUM_TERMS) begin
            prdata = cse_pkg::APB_DATA_W'(r_num_terms);
        end else begin
            prdata = r_rd_vld ? q_b : '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_sat;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == cse_pkg::ST_MUL))
        else $error("accepted point did not start the multiply step");

    a_term_loops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == cse_pkg::ST_ADD) && !final_step) |=>
            ((r_state == cse_pkg::ST_MUL) && (r_idx == $past(r_idx) - IDX_W'(1))))
        else $error("recurrence step did not advance to the next term");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_m_valid && (r_state == cse_pkg::ST_IDLE)))
        else $error("final step did not load the output register");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cse_pkg::ST_IDLE) |-> (r_idx <= IDX_W'(MAX_TERMS - 1)))
        else $error("coefficient index beyond term limit");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == cse_pkg::ST_ADD) && final_step && !out_free) |=>
            (!s_axis_tready && (r_state == cse_pkg::ST_ADD)))
        else $error("final step left while output register was full");

endmodule

### bench/tb_chebyshev_series_eval.sv
module tb_chebyshev_series_eval;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TERMS   = 7;
    localparam int FRAC_BITS   = 16;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [cse_pkg::OUT_W-1:0] value;
        logic                      sat;
    } t_series_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [cse_pkg::S_TDATA_W-1:0]      s_axis_tdata = '0;   // [17:0] point
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [cse_pkg::M_TDATA_W-1:0]      m_axis_tdata;        // [31:0] series_value
    logic [cse_pkg::M_TUSER_W-1:0]      m_axis_tuser;        // [0] saturated
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [cse_pkg::APB_ADDR_W-1:0]     paddr = '0;
    logic [cse_pkg::APB_DATA_W-1:0]     pwdata = '0;
    logic [cse_pkg::APB_DATA_W-1:0]     prdata;
    logic                               pready;

    // shadow of the block's registers, updated at the write transaction
    logic [cse_pkg::TERMS_W-1:0]        terms_cfg = 3'd1;
    longint                             coef_cfg [7] = '{default: 0};
    logic [cse_pkg::COEF_W-1:0]         coef_next [7];

    logic [cse_pkg::POINT_W-1:0]        point_q [$];
    t_series_result                     sum_q [$];
    int                                 points_sent = 0;
    int                                 sums_seen = 0;
    int                                 bad_count = 0;
    int                                 gap_pct = 0;
    int                                 stall_pct = 0;
    int                                 gap_left = 0;
    int                                 stall_left = 0;
    int                                 quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    chebyshev_series_eval #(
        .MAX_TERMS(MAX_TERMS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // floor((p + 2^(s-1)) / 2^s)
    function automatic longint round_half_up(input longint p, input int s);
        return (p + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi,
                                    inout logic flag);
        if (v < lo) begin
            flag = 1'b1;
            return lo;
        end
        if (v > hi) begin
            flag = 1'b1;
            return hi;
        end
        return v;
    endfunction

    // clenshaw recurrence over the shadow configuration
    function automatic t_series_result eval_series(
        input logic signed [cse_pkg::POINT_W-1:0] x);
        longint         xs;
        longint         b0;
        longint         b1;
        longint         b2;
        longint         y;
        int             n;
        t_series_result r;
        xs = x;
        n = int'(terms_cfg);
        if (n < 1) n = 1;
        if (n > MAX_TERMS) n = MAX_TERMS;
        b1 = 0;
        b2 = 0;
        r.sat = 1'b0;
        for (int j = n - 1; j >= 1; j--) begin
            b0 = coef_cfg[j] + round_half_up(xs * b1, FRAC_BITS - 1) - b2;
            b0 = clip(b0, cse_pkg::ACC_MIN, cse_pkg::ACC_MAX, r.sat);
            b2 = b1;
            b1 = b0;
        end
        y = coef_cfg[0] + round_half_up(xs * b1, FRAC_BITS) - b2;
        y = clip(y, cse_pkg::OUT_MIN, cse_pkg::OUT_MAX, r.sat);
        r.value = y[cse_pkg::OUT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        bad_count++;
        if (bad_count <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    // point driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                sum_q.push_back(eval_series(s_axis_tdata[cse_pkg::POINT_W-1:0]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if ($urandom_range(0, 99) < gap_pct) begin
                    gap_left <= $urandom_range(0, 16);
                    s_axis_tvalid <= 1'b0;
                end else if (point_q.size() != 0) begin
                    s_axis_tdata <= {{(cse_pkg::S_TDATA_W-cse_pkg::POINT_W){1'b0}},
                                     point_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_series_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (sum_q.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("result %h with no expected sum pending", m_axis_tdata);
                end else begin
                    want = sum_q.pop_front();
                    if (m_axis_tdata[cse_pkg::OUT_W-1:0] !== want.value)
                        flag_mismatch("series_value", want.value,
                                      m_axis_tdata[cse_pkg::OUT_W-1:0]);
                    if (m_axis_tuser[0] !== want.sat)
                        flag_mismatch("saturated", 32'(want.sat), 32'(m_axis_tuser[0]));
                end
                sums_seen++;
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left <= $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                     || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_chebyshev_series_eval: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_write(input cse_pkg::t_reg_idx idx,
                             input logic [cse_pkg::APB_DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == cse_pkg::REG_NUM_TERMS)
            terms_cfg = val[cse_pkg::TERMS_W-1:0];
        else
            coef_cfg[int'(idx) - 1] = $signed(val[cse_pkg::COEF_W-1:0]);
    endtask

    task automatic program_regs(input logic [cse_pkg::TERMS_W-1:0] terms);
        apb_write(cse_pkg::REG_NUM_TERMS, 32'(terms));
        for (int k = 0; k < 7; k++)
            apb_write(cse_pkg::t_reg_idx'(k + 1), coef_next[k]);
    endtask

    task automatic send_point(input logic [cse_pkg::POINT_W-1:0] p);
        point_q.push_back(p);
        points_sent++;
    endtask

    task automatic wait_drained();
        while (sums_seen < points_sent) @(posedge i_clk);
    endtask

    function automatic logic [cse_pkg::POINT_W-1:0] rand_point();
        case ($urandom_range(0, 19))
            0, 1, 2: return cse_pkg::POINT_W'($urandom);
            3, 4: begin
                case ($urandom_range(0, 6))
                    0: return 18'h10000;
                    1: return 18'h30000;
                    2: return 18'h1FFFF;
                    3: return 18'h20000;
                    4: return 18'h00001;
                    5: return 18'h3FFFF;
                    default: return 18'h00000;
                endcase
            end
            default: return cse_pkg::POINT_W'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    function automatic logic [cse_pkg::COEF_W-1:0] rand_coef(input int kind);
        case (kind)
            0: return cse_pkg::COEF_W'($urandom_range(0, 2**19 - 1) - 2**18);
            1: return $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic int rand_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 40;
        endcase
    endfunction

    initial begin
        int kind;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct = 20;
        stall_pct = 20;

        // registers as they come out of reset
        send_point(18'h00000);
        send_point(18'h10000);
        send_point(18'h30000);
        wait_drained();

        // single term ignores every coefficient above c0
        coef_next[0] = 32'h7FFF_FFFF;
        coef_next[1] = 32'h1234_5678;
        for (int k = 2; k < 7; k++)
            coef_next[k] = 32'hDEAD_BEEF;
        program_regs(3'd1);
        send_point(18'h10000);
        send_point(18'h20000);
        wait_drained();

        // zero terms behaves as one term
        coef_next[0] = 32'h8000_0000;
        program_regs(3'd0);
        send_point(18'h1FFFF);
        send_point(18'h00001);
        wait_drained();

        // largest coefficients, full length: the result clips at x = 1.0
        for (int k = 0; k < 7; k++)
            coef_next[k] = 32'h7FFF_FFFF;
        program_regs(3'd7);
        send_point(18'h10000);
        send_point(18'h30000);
        send_point(18'h1FFFF);
        send_point(18'h20000);
        send_point(18'h00000);
        wait_drained();

        for (int k = 0; k < 7; k++)
            coef_next[k] = 32'h8000_0000;
        program_regs(3'd7);
        send_point(18'h10000);
        send_point(18'h20000);
        send_point(18'h08000);
        wait_drained();

        coef_next[0] = 32'h0001_0000;
        coef_next[1] = 32'h0000_8000;
        coef_next[2] = 32'hFFFF_C000;
        program_regs(3'd3);
        send_point(18'h08000);
        send_point(18'h38000);
        send_point(18'h3FFFF);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = rand_idle_pct();
                stall_pct = rand_idle_pct();
            end
            kind = $urandom_range(0, 3);
            for (int k = 0; k < 7; k++)
                coef_next[k] = rand_coef(kind == 3 ? $urandom_range(0, 2) : kind);
            program_regs(cse_pkg::TERMS_W'($urandom_range(0, 7)));
            for (int k = 0; k < 50; k++)
                send_point(rand_point());
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (sum_q.size() != 0) begin
            bad_count += sum_q.size();
            $display("%0d expected sums never arrived", sum_q.size());
        end
        if (bad_count == 0) begin
            $display("tb_chebyshev_series_eval: PASS");
        end else begin
            $display("tb_chebyshev_series_eval: FAIL");
        end
        $finish;
    end

endmodule
